/* rtl/lrhg_pkg.sv */
// Package for the log record header generator.
// Holds the word types, the CRC-32 constants and the byte-wise CRC update.
// No dependencies.
package lrhg_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;

    localparam word_t CRC_POLY  = 32'hEDB8_8320;
    localparam word_t CRC_ONES  = 32'hFFFF_FFFF;
    localparam word_t COUNT_MAX = 32'hFFFF_FFFF;

    // Reflected CRC-32 update over one byte, least significant bit first.
    function automatic word_t crc_byte(input word_t crc, input byte_t data);
        word_t c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/log_record_header_generator_core.sv */
// Top level of the log record header generator (CRC-32 record framer).
// Holds the input register, running CRC, byte count, sequence counter and result register.
// Depends on lrhg_pkg.
//
// Usage:
// The input channel takes one item per cycle while in_stall is low: a payload
// byte, a flag that says whether the byte is present, and a mark on the last
// item of a record. An item with byte_present low and last_of_record high closes
// an empty record; an item with both low changes nothing.
// For each item that carries the last mark, the output channel gives one item:
// the record's sequence number, its payload length (saturating at all ones) and
// its CRC-32 with the final inversion applied.
// An accepted item sits in the input register. When an item with the last mark
// leaves it, the CRC update lands in the result register, which drives out_valid.
// Throughput is one item per cycle. The only limit is the single result
// register: while it holds a result that the receiver stalls, an item with the
// last mark waits in the input register, and in_stall rises. Items without the
// last mark keep flowing while the output is stalled.
// Reset clears both valid flags, sets the CRC to all ones and clears the byte
// count and the sequence counter. Sequence numbers wrap from all ones to zero.
module log_record_header_generator_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lrhg_pkg::byte_t  payload_byte,
    input  logic             byte_present,
    input  logic             last_of_record,
    output logic             out_valid,
    input  logic             out_stall,
    output lrhg_pkg::word_t  record_seq,
    output lrhg_pkg::word_t  record_length,
    output lrhg_pkg::word_t  record_crc
);
    import lrhg_pkg::*;

    // Input register.
    logic  s1_valid_reg;
    logic  s1_valid_next;
    byte_t s1_byte_reg;
    logic  s1_present_reg;
    logic  s1_last_reg;

    // Running record state.
    word_t crc_reg;
    word_t crc_next;
    word_t count_reg;
    word_t count_next;
    word_t seq_reg;
    word_t seq_next;

    // Result register.
    logic  out_valid_reg;
    logic  out_valid_next;
    word_t out_seq_reg;
    word_t out_len_reg;
    word_t out_crc_reg;

    logic  out_free;
    logic  s1_fire;
    logic  in_fire;
    word_t crc_upd;
    word_t count_upd;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    // The held item leaves unless it needs the result register and that is busy.
    assign s1_fire  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    // Fold the held byte into the CRC and the count.
    always_comb
    begin
        crc_upd   = crc_reg;
        count_upd = count_reg;
        if (s1_present_reg)
        begin
            crc_upd = crc_byte(crc_reg, s1_byte_reg);
            if (count_reg != COUNT_MAX)
            begin
                count_upd = count_reg + 32'd1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
            if (s1_last_reg)
            begin
                // Record closes: the result takes the updated state, then it restarts.
                out_valid_next = 1'b1;
                crc_next       = CRC_ONES;
                count_next     = '0;
                seq_next       = seq_reg + 32'd1;
            end
            else
            begin
                crc_next   = crc_upd;
                count_next = count_upd;
            end
        end
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_ONES;
            count_reg     <= '0;
            seq_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            seq_reg       <= seq_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg    <= payload_byte;
            s1_present_reg <= byte_present;
            s1_last_reg    <= last_of_record;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_seq_reg <= seq_reg;
            out_len_reg <= count_upd;
            out_crc_reg <= crc_upd ^ CRC_ONES;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_seq    = out_seq_reg;
    assign record_length = out_len_reg;
    assign record_crc    = out_crc_reg;

    // A closed record always shows up as a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> out_valid_reg)
        else $error("closed record produced no result");

    // Input backpressure only comes from a final item blocked by a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_last_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked final item");

    // After a record closes the CRC and count restart.
    a_record_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> crc_reg == CRC_ONES && count_reg == '0)
        else $error("record state not restarted");

    // The sequence counter advances by exactly one per closed record.
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> seq_reg == $past(seq_reg) + 32'd1)
        else $error("sequence counter did not advance by one");

    // The sequence counter never moves without a closed record.
    a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_fire && s1_last_reg) |=> $stable(seq_reg))
        else $error("sequence counter moved without a record");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for log_record_header_generator_core, the CRC-32 record framer.
// It drives byte items over a valid/stall channel and predicts each record header.
// Depends on lrhg_pkg and the core RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import lrhg_pkg::word_t;
    import lrhg_pkg::byte_t;
    import lrhg_pkg::CRC_POLY;
    import lrhg_pkg::CRC_ONES;
    import lrhg_pkg::COUNT_MAX;

    // One finished record header, as the block should report it.
    typedef struct packed
    {
        word_t seq;
        word_t len;
        word_t crc;
    } record_hdr_t;

    logic  clk            = 1'b0;
    logic  rst_n          = 1'b0;
    logic  in_valid       = 1'b0;
    logic  in_stall;
    byte_t payload_byte   = '0;
    logic  byte_present   = 1'b0;
    logic  last_of_record = 1'b0;
    logic  out_valid;
    logic  out_stall      = 1'b0;
    word_t record_seq;
    word_t record_length;
    word_t record_crc;

    // Predicted framer state: running CRC, saturating length, next sequence number.
    word_t run_crc  = CRC_ONES;
    word_t run_len  = '0;
    word_t seq_next = '0;

    // Headers predicted but not yet delivered, oldest first.
    record_hdr_t hdr_pending[$];

    int error_count = 0;
    int items_sent  = 0;

    // Idling controls. The test tasks switch these on and off in stretches.
    // long_hold asks the result sink to keep stall high for that many cycles.
    bit source_idle = 1'b1;
    bit sink_idle   = 1'b1;
    int long_hold   = 0;

    log_record_header_generator_core DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .payload_byte   (payload_byte),
        .byte_present   (byte_present),
        .last_of_record (last_of_record),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .record_seq     (record_seq),
        .record_length  (record_length),
        .record_crc     (record_crc)
    );

    always #4 clk = ~clk;

    // Bit-serial reflected CRC-32: each data bit, least significant first, is
    // folded into bit 0 of the register before the shift.
    function automatic word_t crc32_shift_byte(input word_t crc, input byte_t data);
        word_t acc;
        logic  fb;
        acc = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ data[i];
            acc = (acc >> 1) ^ (fb ? CRC_POLY : word_t'(0));
        end
        return acc;
    endfunction

    // Advance the predicted framer state by one accepted item. An item with the
    // last mark closes the record, after its own byte (if any) is counted.
    function automatic void predict_item(input byte_t data, input logic present,
                                         input logic last);
        record_hdr_t hdr;
        if (present)
        begin
            run_crc = crc32_shift_byte(run_crc, data);
            if (run_len != COUNT_MAX)
                run_len++;
        end
        if (last)
        begin
            hdr.seq = seq_next;
            hdr.len = run_len;
            hdr.crc = run_crc ^ CRC_ONES;
            hdr_pending.push_back(hdr);
            seq_next++;
            run_crc = CRC_ONES;
            run_len = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        error_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Offer one item and hold it until the block takes it. Must be called in the
    // time step of a rising edge, so that every drive lands on an edge.
    task automatic send_item(input byte_t data, input logic present, input logic last);
        int gap;
        gap = source_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        payload_byte   <= data;
        byte_present   <= present;
        last_of_record <= last;
        do @(posedge clk); while (in_stall);
        predict_item(data, present, last);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted header has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (hdr_pending.size() != 0);
    endtask

    // Mostly short records, now and then a longer one.
    function automatic int pick_length();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(13, 48);
        return $urandom_range(0, 12);
    endfunction

    // One well-formed record with random bytes and idle items sprinkled in. Empty
    // records, and about a quarter of the others, close with a separate byteless item.
    task automatic send_record(input int nbytes);
        bit empty_close;
        empty_close = (nbytes == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(byte_t'($urandom), 1'b0, 1'b0);
            send_item(byte_t'($urandom), 1'b1, !empty_close && (i == nbytes - 1));
        end
        if (empty_close)
            send_item(byte_t'($urandom), 1'b0, 1'b1);
    endtask

    // Result sink. For every header it may first hold stall high while sink_idle
    // is set, then lowers stall and waits for out_valid. A long hold requested by a
    // test is picked up while waiting and counted out here, cycle by cycle.
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = sink_idle ? $urandom_range(0, 9) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid && long_hold == 0)
                @(posedge clk);
            if (long_hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (long_hold) @(posedge clk);
                long_hold = 0;
            end
        end
    end

    // Header checker: every header taken at an edge is compared with the oldest
    // prediction. Values are read right after the edge, before any update.
    always @(posedge clk)
    begin
        record_hdr_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (hdr_pending.size() == 0)
            begin
                report_mismatch("header with no record closed, record_seq",
                                record_seq, '0);
            end
            else
            begin
                want = hdr_pending.pop_front();
                if (record_seq !== want.seq)
                    report_mismatch("record_seq", record_seq, want.seq);
                if (record_length !== want.len)
                    report_mismatch("record_length", record_length, want.len);
                if (record_crc !== want.crc)
                    report_mismatch("record_crc", record_crc, want.crc);
            end
        end
    end

    // Hand-picked items: an empty record straight out of reset (length 0, CRC 0),
    // idle items, one-byte records at both byte extremes, the standard check
    // string, a record closed by an item without a byte after idles, and two
    // empty records in a row.
    task automatic test_directed();
        byte_t check_str[9];
        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        foreach (check_str[i])
            send_item(check_str[i], 1'b1, i == 8);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        drain_results();
    endtask

    // Full rate on both sides: one-byte records every cycle keep the single
    // result register busy, then ordinary records follow without gaps.
    task automatic test_streaming();
        source_idle = 1'b0;
        sink_idle   = 1'b0;
        for (int i = 0; i < 40; i++)
            send_item(byte_t'($urandom), 1'b1, 1'b1);
        for (int i = 0; i < 10; i++)
            send_record(pick_length());
        drain_results();
        source_idle = 1'b1;
        sink_idle   = 1'b1;
    endtask

    // The sink holds stall for a long stretch while the source keeps offering
    // short records, so that the block fills up and raises in_stall.
    task automatic test_result_backpressure();
        source_idle = 1'b0;
        long_hold   = 200;
        for (int i = 0; i < 12; i++)
            send_record($urandom_range(0, 4));
        drain_results();
        source_idle = 1'b1;
    endtask

    // The source waits after every record until its header has been delivered.
    task automatic test_record_at_a_time();
        for (int i = 0; i < 8; i++)
        begin
            send_record(pick_length());
            drain_results();
        end
    endtask

    // Bulk random traffic: mostly well-formed records, with bursts of idle
    // items as noise and idling switched on and off in stretches.
    task automatic test_random_records();
        int target;
        target = items_sent + 800;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                source_idle = $urandom_range(0, 2) != 0;
                sink_idle   = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 5))
                    send_item(byte_t'($urandom), 1'b0, 1'b0);
            end
            else
            begin
                send_record(pick_length());
            end
        end
        source_idle = 1'b1;
        sink_idle   = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_streaming();
        test_result_backpressure();
        test_record_at_a_time();
        test_random_records();

        drain_results();
        // The last items may have been idle ones still in the pipeline.
        repeat (8) @(posedge clk);
        foreach (hdr_pending[i])
            report_mismatch("header never delivered, record_seq", '0, hdr_pending[i].seq);

        if (error_count == 0)
            $display("log_record_header_generator_core verification clean");
        else
            $display("log_record_header_generator_core verification failed");
        $finish;
    end

    // Watchdog, many times the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("log_record_header_generator_core verification failed");
        $finish;
    end

endmodule
